>>> src/tbig_pkg.sv
// Shared types, constants and helper function of the tile broadcast index generator.
package tbig_pkg;

    localparam int TILE_SIDE            = 32;
    localparam int POS_W                = 5;
    localparam int TILE_INDEX_BITS_DEF  = 24;
    localparam int TPR_W                = 12;
    localparam int DIM_W                = 16;
    localparam int ELEM_W               = 10;
    localparam int CFG_IDX_W            = 3;
    localparam int CFG_DATA_W           = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_RANK           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COORD_SELECT         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_ROWS           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COLS           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ROWS          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COLS          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_TILES_PER_ROW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TILES_PER_ROW = 3'd7;

    localparam logic [1:0] RANK_VECTOR = 2'd1;
    localparam logic [1:0] RANK_MATRIX = 2'd2;

    localparam logic [1:0]       RST_INPUT_RANK   = 2'd2;
    localparam logic [1:0]       RST_COORD_SELECT = 2'd2;
    localparam logic [DIM_W-1:0] RST_INPUT_ROWS   = 16'd1;
    localparam logic [DIM_W-1:0] RST_INPUT_COLS   = 16'd1;
    localparam logic [DIM_W-1:0] RST_OUTPUT_ROWS  = 16'd32;
    localparam logic [DIM_W-1:0] RST_OUTPUT_COLS  = 16'd32;
    localparam logic [TPR_W-1:0] RST_TILES_PER_ROW = 12'd1;

    typedef struct packed {
        logic [1:0]       rank;
        logic [1:0]       coord_select;
        logic [DIM_W-1:0] src_rows;
        logic [DIM_W-1:0] src_cols;
        logic [DIM_W-1:0] dst_rows;
        logic [DIM_W-1:0] dst_cols;
        logic [TPR_W-1:0] src_tpr;
        logic [TPR_W-1:0] out_divisor;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    function automatic logic [ELEM_W-1:0] face_offset(input logic [POS_W-1:0] r,
                                                      input logic [POS_W-1:0] c);
        return {r[4], c[4], r[3:0], c[3:0]};
    endfunction

endpackage

>>> src/tbig_cfg_regs.sv
// Configuration register file of the tile broadcast index generator.
module tbig_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbig_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tbig_pkg::cfg_t                   cfg
);
    import tbig_pkg::*;

    logic [1:0]       rank_reg;
    logic [1:0]       sel_reg;
    logic [DIM_W-1:0] in_rows_reg;
    logic [DIM_W-1:0] in_cols_reg;
    logic [DIM_W-1:0] out_rows_reg;
    logic [DIM_W-1:0] out_cols_reg;
    logic [TPR_W-1:0] in_tpr_reg;
    logic [TPR_W-1:0] out_tpr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg     <= RST_INPUT_RANK;
            sel_reg      <= RST_COORD_SELECT;
            in_rows_reg  <= RST_INPUT_ROWS;
            in_cols_reg  <= RST_INPUT_COLS;
            out_rows_reg <= RST_OUTPUT_ROWS;
            out_cols_reg <= RST_OUTPUT_COLS;
            in_tpr_reg   <= RST_TILES_PER_ROW;
            out_tpr_reg  <= RST_TILES_PER_ROW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INPUT_RANK:           rank_reg     <= cfg_data[1:0];
                REG_COORD_SELECT:         sel_reg      <= cfg_data[1:0];
                REG_INPUT_ROWS:           in_rows_reg  <= cfg_data[DIM_W-1:0];
                REG_INPUT_COLS:           in_cols_reg  <= cfg_data[DIM_W-1:0];
                REG_OUTPUT_ROWS:          out_rows_reg <= cfg_data[DIM_W-1:0];
                REG_OUTPUT_COLS:          out_cols_reg <= cfg_data[DIM_W-1:0];
                REG_INPUT_TILES_PER_ROW:  in_tpr_reg   <= cfg_data[TPR_W-1:0];
                REG_OUTPUT_TILES_PER_ROW: out_tpr_reg  <= cfg_data[TPR_W-1:0];
                default:                  ;
            endcase
        end
    end

    // An output tiles-per-row value of zero divides as one.
    always_comb
    begin
        cfg.rank         = rank_reg;
        cfg.coord_select = sel_reg;
        cfg.src_rows     = in_rows_reg;
        cfg.src_cols     = in_cols_reg;
        cfg.dst_rows     = out_rows_reg;
        cfg.dst_cols     = out_cols_reg;
        cfg.src_tpr      = in_tpr_reg;
        cfg.out_divisor  = (out_tpr_reg == '0) ? RST_TILES_PER_ROW : out_tpr_reg;
    end

endmodule

>>> src/tbig_divider.sv
// Pipelined restoring divider that splits the tile index into tile row and tile column.
module tbig_divider #(
    parameter int IDX_W = tbig_pkg::TILE_INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [IDX_W-1:0]             dividend,
    input  tbig_pkg::pos_t               in_pos,
    input  logic [tbig_pkg::TPR_W-1:0]   divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [IDX_W-1:0]             quotient,
    output logic [tbig_pkg::TPR_W-1:0]   remainder,
    output tbig_pkg::pos_t               out_pos
);
    import tbig_pkg::*;

    logic [IDX_W:0]   rdy;
    logic             vld_reg [IDX_W];
    logic [TPR_W-1:0] rem_reg [IDX_W];
    logic [IDX_W-1:0] num_reg [IDX_W];
    pos_t             pos_reg [IDX_W];

    assign rdy[IDX_W] = out_ready;

    for (genvar s = 0; s < IDX_W; s++)
    begin : g_stage
        logic             vld_in;
        logic [TPR_W-1:0] rem_in;
        logic [IDX_W-1:0] num_in;
        pos_t             pos_in;
        logic [TPR_W:0]   trial;
        logic [TPR_W:0]   diff;
        logic             ge;
        logic [TPR_W-1:0] rem_next;
        logic [IDX_W-1:0] num_next;

        if (s == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign num_in = dividend;
            assign pos_in = in_pos;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign pos_in = pos_reg[s-1];
        end

        assign rdy[s]   = !vld_reg[s] || rdy[s+1];
        assign trial    = {rem_in, num_in[IDX_W-1]};
        assign diff     = trial - {1'b0, divisor};
        assign ge       = (trial >= {1'b0, divisor});
        assign rem_next = ge ? diff[TPR_W-1:0] : trial[TPR_W-1:0];
        assign num_next = {num_in[IDX_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                rem_reg[s] <= rem_next;
                num_reg[s] <= num_next;
                pos_reg[s] <= pos_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[IDX_W-1];
    assign quotient  = num_reg[IDX_W-1];
    assign remainder = rem_reg[IDX_W-1];
    assign out_pos   = pos_reg[IDX_W-1];

endmodule

>>> src/tbig_map.sv
// Coordinate mapping, bounds check and source tile index stages.
module tbig_map #(
    parameter int IDX_W = tbig_pkg::TILE_INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbig_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [IDX_W-1:0]              quotient,
    input  logic [tbig_pkg::TPR_W-1:0]    remainder,
    input  tbig_pkg::pos_t                in_pos,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              src_tile_index,
    output logic [tbig_pkg::ELEM_W-1:0]   src_offset,
    output logic [tbig_pkg::ELEM_W-1:0]   dst_offset,
    output logic                          in_bounds
);
    import tbig_pkg::*;

    localparam int HI_W   = (IDX_W > TPR_W) ? IDX_W : TPR_W;
    localparam int ROW_W  = IDX_W + POS_W;
    localparam int COL_W  = TPR_W + POS_W;
    localparam int CMP_W  = (ROW_W > DIM_W) ? ROW_W : DIM_W;
    localparam int PROD_W = HI_W + TPR_W;

    logic rdy_a;
    logic rdy_b;
    logic rdy_c;

    logic              a_vld_reg;
    logic [HI_W-1:0]   a_srow_hi_reg;
    logic [HI_W-1:0]   a_scol_hi_reg;
    logic [ELEM_W-1:0] a_src_elem_reg;
    logic [ELEM_W-1:0] a_dst_elem_reg;
    logic              a_inb_reg;

    logic              b_vld_reg;
    logic [IDX_W-1:0]  b_prod_reg;
    logic [IDX_W-1:0]  b_scol_reg;
    logic [ELEM_W-1:0] b_src_elem_reg;
    logic [ELEM_W-1:0] b_dst_elem_reg;
    logic              b_inb_reg;

    logic              c_vld_reg;
    logic [IDX_W-1:0]  c_tile_reg;
    logic [ELEM_W-1:0] c_src_elem_reg;
    logic [ELEM_W-1:0] c_dst_elem_reg;
    logic              c_inb_reg;

    logic [HI_W-1:0]   orow_hi;
    logic [HI_W-1:0]   ocol_hi;
    logic [HI_W-1:0]   d0_hi;
    logic [POS_W-1:0]  d0_lo;
    logic [HI_W-1:0]   d1_hi;
    logic [POS_W-1:0]  d1_lo;
    logic [HI_W-1:0]   a_srow_hi_next;
    logic [HI_W-1:0]   a_scol_hi_next;
    logic [POS_W-1:0]  srow_lo;
    logic [POS_W-1:0]  scol_lo;
    logic [ROW_W-1:0]  orow;
    logic [COL_W-1:0]  ocol;
    logic              a_inb_next;
    logic [ELEM_W-1:0] a_src_elem_next;
    logic [PROD_W-1:0] prod_full;
    logic [IDX_W-1:0]  c_tile_next;

    assign rdy_c    = !c_vld_reg || out_ready;
    assign rdy_b    = !b_vld_reg || rdy_c;
    assign rdy_a    = !a_vld_reg || rdy_b;
    assign in_ready = rdy_a;

    assign orow_hi = HI_W'(quotient);
    assign ocol_hi = HI_W'(remainder);
    assign orow    = {quotient, in_pos.row};
    assign ocol    = {remainder, in_pos.col};

    always_comb
    begin
        d0_hi = cfg.coord_select[0] ? ocol_hi : orow_hi;
        d0_lo = cfg.coord_select[0] ? in_pos.col : in_pos.row;
        d1_hi = cfg.coord_select[1] ? ocol_hi : orow_hi;
        d1_lo = cfg.coord_select[1] ? in_pos.col : in_pos.row;
        a_srow_hi_next = '0;
        srow_lo        = '0;
        a_scol_hi_next = '0;
        scol_lo        = '0;
        case (cfg.rank)
            RANK_VECTOR:
            begin
                if (cfg.src_cols != RST_INPUT_COLS)
                begin
                    a_scol_hi_next = d0_hi;
                    scol_lo        = d0_lo;
                end
            end
            RANK_MATRIX:
            begin
                if (cfg.src_rows != RST_INPUT_ROWS)
                begin
                    a_srow_hi_next = d0_hi;
                    srow_lo        = d0_lo;
                end
                if (cfg.src_cols != RST_INPUT_COLS)
                begin
                    a_scol_hi_next = d1_hi;
                    scol_lo        = d1_lo;
                end
            end
            default:
            begin
                a_srow_hi_next = '0;
                a_scol_hi_next = '0;
            end
        endcase
        a_inb_next = (CMP_W'(orow) < CMP_W'(cfg.dst_rows))
                     && (ocol < COL_W'(cfg.dst_cols));
        a_src_elem_next = a_inb_next ? face_offset(srow_lo, scol_lo) : '0;
    end

    assign prod_full   = PROD_W'(a_srow_hi_reg) * PROD_W'(cfg.src_tpr);
    assign c_tile_next = b_prod_reg + b_scol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                a_vld_reg <= in_valid;
            end
            if (rdy_b)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (rdy_c)
            begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_srow_hi_reg  <= a_srow_hi_next;
            a_scol_hi_reg  <= a_scol_hi_next;
            a_src_elem_reg <= a_src_elem_next;
            a_dst_elem_reg <= face_offset(in_pos.row, in_pos.col);
            a_inb_reg      <= a_inb_next;
        end
        if (rdy_b)
        begin
            b_prod_reg     <= prod_full[IDX_W-1:0];
            b_scol_reg     <= a_scol_hi_reg[IDX_W-1:0];
            b_src_elem_reg <= a_src_elem_reg;
            b_dst_elem_reg <= a_dst_elem_reg;
            b_inb_reg      <= a_inb_reg;
        end
        if (rdy_c)
        begin
            c_tile_reg     <= c_tile_next;
            c_src_elem_reg <= b_src_elem_reg;
            c_dst_elem_reg <= b_dst_elem_reg;
            c_inb_reg      <= b_inb_reg;
        end
    end

    assign out_valid      = c_vld_reg;
    assign src_tile_index = c_tile_reg;
    assign src_offset     = c_src_elem_reg;
    assign dst_offset     = c_dst_elem_reg;
    assign in_bounds      = c_inb_reg;

endmodule

>>> src/tile_broadcast_index_gen_core.sv
// Top level of the tile broadcast index generator.
//
//   Channel  Direction  Handshake           Payload
//   in       sink       in_valid/in_stall   out_tile_index, row_in_tile, col_in_tile
//   out      source     out_valid/out_stall src_tile_index, src_offset, dst_offset,
//                                           in_bounds
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low; each passes through the
// divider, which produces one quotient bit per stage, and then the stages of the map.
// The reset is asynchronous and empties the pipeline; the registers return to their
// reset values. Every stage holds its transaction while the next one is full, so a
// stalled output still lets transactions enter until the pipeline is full.
module tile_broadcast_index_gen_core #(
    parameter int TILE_INDEX_BITS = tbig_pkg::TILE_INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [TILE_INDEX_BITS-1:0]       out_tile_index,
    input  logic [tbig_pkg::POS_W-1:0]       row_in_tile,
    input  logic [tbig_pkg::POS_W-1:0]       col_in_tile,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [TILE_INDEX_BITS-1:0]       src_tile_index,
    output logic [tbig_pkg::ELEM_W-1:0]      src_offset,
    output logic [tbig_pkg::ELEM_W-1:0]      dst_offset,
    output logic                             in_bounds,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbig_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tbig_pkg::*;

    cfg_t                       cfg;
    pos_t                       in_pos;
    pos_t                       div_pos;
    logic                       div_in_ready;
    logic                       div_valid;
    logic                       map_in_ready;
    logic [TILE_INDEX_BITS-1:0] div_quotient;
    logic [TPR_W-1:0]           div_remainder;

    assign in_pos.row = row_in_tile;
    assign in_pos.col = col_in_tile;
    assign in_stall   = !div_in_ready;

    tbig_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbig_divider #(
        .IDX_W (TILE_INDEX_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (div_in_ready),
        .dividend  (out_tile_index),
        .in_pos    (in_pos),
        .divisor   (cfg.out_divisor),
        .out_valid (div_valid),
        .out_ready (map_in_ready),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .out_pos   (div_pos)
    );

    tbig_map #(
        .IDX_W (TILE_INDEX_BITS)
    ) u_map (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (div_valid),
        .in_ready       (map_in_ready),
        .quotient       (div_quotient),
        .remainder      (div_remainder),
        .in_pos         (div_pos),
        .out_valid      (out_valid),
        .out_ready      (!out_stall),
        .src_tile_index (src_tile_index),
        .src_offset     (src_offset),
        .dst_offset     (dst_offset),
        .in_bounds      (in_bounds)
    );

endmodule

>>> src/tbig_checker.sv
// Port-level checker of the tile broadcast index generator and its bind statement.
module tbig_checker #(
    parameter int IDX_W = tbig_pkg::TILE_INDEX_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [IDX_W-1:0]                 src_tile_index,
    input logic [tbig_pkg::ELEM_W-1:0]      src_offset,
    input logic [tbig_pkg::ELEM_W-1:0]      dst_offset,
    input logic                             in_bounds
);
    import tbig_pkg::*;

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_take && !out_take)
        begin
            pend_next = pend_reg + 8'd1;
        end
        else if (out_take && !in_take)
        begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(src_tile_index)
            && $stable(src_offset) && $stable(dst_offset) && $stable(in_bounds))
        else $error("Stalled result transaction changed or was dropped.");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("Result transaction shown with no input transaction pending.");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 8'd0 |-> !in_stall)
        else $error("Input stalled while no transaction is in flight.");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_bounds |-> src_offset == '0)
        else $error("Out-of-bounds result carries a non-zero source element.");

endmodule

bind tile_broadcast_index_gen_core tbig_checker #(.IDX_W(TILE_INDEX_BITS)) u_tbig_checker (.*);

>>> dv/tile_broadcast_index_gen_core_tb.sv
// Self-checking testbench for the tile broadcast index generator core.
module tile_broadcast_index_gen_core_tb;
    import tbig_pkg::*;

    localparam int TIB = TILE_INDEX_BITS_DEF;
    localparam logic [TIB-1:0] MAX_TILE = {TIB{1'b1}};
    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 43;

    localparam logic [1:0] RANK_FIXED_LO = 2'd0;
    localparam logic [1:0] RANK_FIXED_HI = 2'd3;
    localparam logic [1:0] CSEL_ROW_ROW = 2'd0;
    localparam logic [1:0] CSEL_COL_ROW = 2'd1;
    localparam logic [1:0] CSEL_ROW_COL = 2'd2;
    localparam logic [1:0] CSEL_COL_COL = 2'd3;

    typedef struct packed {
        logic [TIB-1:0]    src_tile;
        logic [ELEM_W-1:0] src_el;
        logic [ELEM_W-1:0] dst_el;
        logic              inb;
    } addr_result_t;

    class broadcast_addr_checker;
        cfg_t           regs;
        addr_result_t   expected_addrs[$];
        int unsigned    mismatches;
        int unsigned    checked;
        int unsigned    hits_in_bounds;

        function new();
            regs.rank         = RST_INPUT_RANK;
            regs.coord_select = RST_COORD_SELECT;
            regs.src_rows     = RST_INPUT_ROWS;
            regs.src_cols     = RST_INPUT_COLS;
            regs.dst_rows     = RST_OUTPUT_ROWS;
            regs.dst_cols     = RST_OUTPUT_COLS;
            regs.src_tpr      = RST_TILES_PER_ROW;
            regs.out_divisor  = RST_TILES_PER_ROW;
            mismatches        = 0;
            checked           = 0;
            hits_in_bounds    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INPUT_RANK:           regs.rank         = data[1:0];
                REG_COORD_SELECT:         regs.coord_select = data[1:0];
                REG_INPUT_ROWS:           regs.src_rows     = data[DIM_W-1:0];
                REG_INPUT_COLS:           regs.src_cols     = data[DIM_W-1:0];
                REG_OUTPUT_ROWS:          regs.dst_rows     = data[DIM_W-1:0];
                REG_OUTPUT_COLS:          regs.dst_cols     = data[DIM_W-1:0];
                REG_INPUT_TILES_PER_ROW:  regs.src_tpr      = data[TPR_W-1:0];
                REG_OUTPUT_TILES_PER_ROW: regs.out_divisor  = data[TPR_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned face_layout(longint unsigned r, longint unsigned c);
            return ((r / 16) * 2 + (c / 16)) * 256 + (r % 16) * 16 + (c % 16);
        endfunction

        function void note_element(logic [TIB-1:0] tile, logic [POS_W-1:0] row,
                                   logic [POS_W-1:0] col);
            longint unsigned divisor, orow, ocol, srow, scol, first_c, second_c;
            addr_result_t    e;
            divisor = (regs.out_divisor == 0) ? 1 : longint'(regs.out_divisor);
            orow = (longint'(tile) / divisor) * TILE_SIDE + longint'(row);
            ocol = (longint'(tile) % divisor) * TILE_SIDE + longint'(col);
            first_c  = regs.coord_select[0] ? ocol : orow;
            second_c = regs.coord_select[1] ? ocol : orow;
            srow = 0;
            scol = 0;
            if (regs.rank == RANK_VECTOR)
            begin
                scol = (regs.src_cols == 1) ? 0 : first_c;
            end
            else if (regs.rank == RANK_MATRIX)
            begin
                srow = (regs.src_rows == 1) ? 0 : first_c;
                scol = (regs.src_cols == 1) ? 0 : second_c;
            end
            e.inb = (orow < longint'(regs.dst_rows)) && (ocol < longint'(regs.dst_cols));
            e.src_tile = TIB'((srow / TILE_SIDE) * longint'(regs.src_tpr)
                              + scol / TILE_SIDE);
            e.src_el = e.inb ? ELEM_W'(face_layout(srow % TILE_SIDE, scol % TILE_SIDE)) : '0;
            e.dst_el = ELEM_W'(face_layout(longint'(row), longint'(col)));
            expected_addrs.push_back(e);
        endfunction

        function void check_addr(addr_result_t got);
            addr_result_t e;
            checked++;
            if (expected_addrs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected: tile %h src %h dst %h inb %b",
                             got.src_tile, got.src_el, got.dst_el, got.inb);
                return;
            end
            e = expected_addrs.pop_front();
            if (got.src_tile !== e.src_tile || got.src_el !== e.src_el ||
                got.dst_el !== e.dst_el || got.inb !== e.inb)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %h %h %h %b, got %h %h %h %b",
                             checked, e.src_tile, e.src_el, e.dst_el, e.inb,
                             got.src_tile, got.src_el, got.dst_el, got.inb);
            end
            else if (got.inb)
            begin
                hits_in_bounds++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [TIB-1:0]        out_tile_index;
    logic [POS_W-1:0]      row_in_tile;
    logic [POS_W-1:0]      col_in_tile;
    logic                  out_valid;
    logic                  out_stall;
    logic [TIB-1:0]        src_tile_index;
    logic [ELEM_W-1:0]     src_offset;
    logic [ELEM_W-1:0]     dst_offset;
    logic                  in_bounds;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    broadcast_addr_checker sb = new();
    int unsigned           items_sent;
    int unsigned           settings_used;
    int unsigned           idle_cycles;
    bit                    burst_mode;

    tile_broadcast_index_gen_core #(
        .TILE_INDEX_BITS(TIB)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .out_tile_index (out_tile_index),
        .row_in_tile    (row_in_tile),
        .col_in_tile    (col_in_tile),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .src_tile_index (src_tile_index),
        .src_offset     (src_offset),
        .dst_offset     (dst_offset),
        .in_bounds      (in_bounds),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_addr({src_tile_index, src_offset, dst_offset, in_bounds});
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tile_broadcast_index_gen_core_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned p, quiet, hold;
        out_stall = 1'b0;
        forever
        begin
            p     = $urandom_range(0, 99);
            quiet = (p < 20) ? $urandom_range(20, 80) : $urandom_range(0, 4);
            hold  = (p >= 90) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            repeat (quiet)
            begin
                @(negedge clk);
                out_stall = 1'b0;
            end
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
        end
    end

    function automatic int unsigned input_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (burst_mode || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic [TIB-1:0] tile, logic [POS_W-1:0] row,
                             logic [POS_W-1:0] col);
        repeat (input_gap())
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid       = 1'b1;
        out_tile_index = tile;
        row_in_tile    = row;
        col_in_tile    = col;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_element(tile, row, col);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_addrs.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_registers(logic [15:0] rank, logic [15:0] csel, logic [15:0] irows,
                                 logic [15:0] icols, logic [15:0] orows, logic [15:0] ocols,
                                 logic [15:0] itpr, logic [15:0] otpr);
        wait_drained();
        cfg_write(REG_INPUT_RANK, rank);
        cfg_write(REG_COORD_SELECT, csel);
        cfg_write(REG_INPUT_ROWS, irows);
        cfg_write(REG_INPUT_COLS, icols);
        cfg_write(REG_OUTPUT_ROWS, orows);
        cfg_write(REG_OUTPUT_COLS, ocols);
        cfg_write(REG_INPUT_TILES_PER_ROW, itpr);
        cfg_write(REG_OUTPUT_TILES_PER_ROW, otpr);
        settings_used++;
    endtask

    function automatic logic [15:0] pick_src_dim();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 15) return 16'd1;
        if (p < 20) return 16'd0;
        if (p < 30) return 16'hffff;
        if (p < 60) return 16'($urandom_range(2, 128));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_extent();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 10) return 16'hffff;
        if (p < 13) return 16'd0;
        if (p < 70) return 16'($urandom_range(1, 400));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_tiles_per_row();
        int unsigned p;
        logic [3:0]  junk;
        p    = $urandom_range(0, 99);
        junk = 4'($urandom);
        if (p < 10) return {junk, 12'd0};
        if (p < 20) return {junk, 12'd1};
        if (p < 30) return {junk, 12'hfff};
        if (p < 70) return {junk, 12'($urandom_range(2, 12))};
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] pick_rank();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 40) return RANK_MATRIX;
        if (p < 75) return RANK_VECTOR;
        if (p < 87) return RANK_FIXED_LO;
        return RANK_FIXED_HI;
    endfunction

    function automatic logic [TIB-1:0] pick_tile();
        int unsigned p, divisor;
        p       = $urandom_range(0, 99);
        divisor = (sb.regs.out_divisor == 0) ? 1 : int'(sb.regs.out_divisor);
        if (p < 60) return TIB'($urandom_range(0, divisor * 4 + 3));
        if (p < 90) return TIB'($urandom);
        return ($urandom_range(0, 1) != 0) ? MAX_TILE : '0;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 10) return ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
        return POS_W'($urandom);
    endfunction

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_tile_index = '0;
        row_in_tile    = '0;
        col_in_tile    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        items_sent     = 0;
        settings_used  = 1;
        idle_cycles    = 0;
        burst_mode     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: both source dimensions are broadcast.
        send_item('0, 5'd0, 5'd0);
        send_item('0, 5'd31, 5'd31);
        send_item('0, 5'd0, 5'd31);
        send_item('0, 5'd31, 5'd0);
        send_item(MAX_TILE, 5'd31, 5'd31);

        // Transposed matrix source with zero output tiles per row.
        set_registers(RANK_MATRIX, CSEL_COL_ROW, 16'd100, 16'd70, 16'd100, 16'd90,
                      16'd4, 16'd0);
        send_item(TIB'(1), 5'd5, 5'd7);
        send_item(TIB'(3), 5'd31, 5'd31);
        send_item(TIB'(2), 5'd17, 5'd20);

        set_registers(RANK_VECTOR, CSEL_COL_ROW, 16'd1, 16'd50, 16'd64, 16'd200,
                      16'd3, 16'd5);
        send_item(TIB'(6), 5'd3, 5'd9);
        send_item(TIB'(9), 5'd31, 5'd31);

        set_registers(RANK_VECTOR, CSEL_ROW_ROW, 16'd7, 16'd1, 16'd64, 16'd64,
                      16'd3, 16'd2);
        send_item(TIB'(3), 5'd12, 5'd30);

        set_registers(RANK_FIXED_LO, CSEL_COL_COL, 16'd40, 16'd40, 16'd64, 16'd64,
                      16'd2, 16'd2);
        send_item(TIB'(3), 5'd31, 5'd31);
        set_registers(RANK_FIXED_HI, CSEL_ROW_COL, 16'd40, 16'd40, 16'd64, 16'd64,
                      16'd2, 16'd2);
        send_item(TIB'(1), 5'd2, 5'd3);

        // Zero source tiles per row, widest extents.
        set_registers(RANK_MATRIX, CSEL_ROW_COL, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'd0, 16'hffff);
        send_item(MAX_TILE, 5'd31, 5'd31);
        send_item(TIB'(4095), 5'd0, 5'd31);

        set_registers(RANK_MATRIX, CSEL_COL_COL, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff);
        send_item(MAX_TILE, 5'd31, 5'd31);
        send_item(MAX_TILE - TIB'(4095), 5'd0, 5'd0);
        send_item(TIB'(4096), 5'd16, 5'd15);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                set_registers(16'hfffe, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 16'hffff);
            else if (ph == 1)
                set_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            else
                set_registers({14'($urandom), pick_rank()}, 16'($urandom), pick_src_dim(),
                              pick_src_dim(), pick_extent(), pick_extent(),
                              pick_tiles_per_row(), pick_tiles_per_row());
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    burst_mode = ~burst_mode;
                send_item(pick_tile(), pick_pos(), pick_pos());
            end
        end

        wait_drained();
        repeat (TIB + 8) @(posedge clk);
        $display("Covered %0d input transactions over %0d register settings.",
                 items_sent, settings_used);
        $display("Checked %0d results, %0d in bounds, %0d mismatches.",
                 sb.checked, sb.hits_in_bounds, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_addrs.size() == 0)
            $display("tile_broadcast_index_gen_core_tb OK");
        else
            $display("tile_broadcast_index_gen_core_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
src/tbig_pkg.sv
src/tbig_cfg_regs.sv
src/tbig_divider.sv
src/tbig_map.sv
src/tile_broadcast_index_gen_core.sv
src/tbig_checker.sv
dv/tile_broadcast_index_gen_core_tb.sv
